// ===== rtl/kcsw_pkg.sv =====
// ============================================================================
// kcsw_pkg
// shared types, field widths and access codes of the keyed count store
// ============================================================================
package kcsw_pkg;

    localparam int SLOTS_DEF = 64;

    localparam int KIND_W  = 2;
    localparam int KEY_W   = 16;
    localparam int AMT_W   = 16;
    localparam int CNT_W   = 16;
    localparam int TOTAL_W = 22;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // access kinds
    localparam logic [KIND_W-1:0] KIND_DEPOSIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WITHDRAW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  item_key;
        logic [AMT_W-1:0]  amount;
    } req_item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] count;
        logic               dropped;
    } rsp_item_t;

    // one table entry; a zero count marks the slot empty
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
    } slot_t;

endpackage

// ===== rtl/kcsw_req_if.sv =====
// ============================================================================
// kcsw_req_if
// request channel: valid/ready handshake carrying one access item
// ============================================================================
interface kcsw_req_if
    import kcsw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  item_key;
    logic [AMT_W-1:0]  amount;

    modport source (output valid, kind, item_key, amount, input ready);
    modport sink   (input valid, kind, item_key, amount, output ready);
endinterface

// ===== rtl/kcsw_rsp_if.sv =====
// ============================================================================
// kcsw_rsp_if
// response channel: valid/ready handshake carrying one result item
// ============================================================================
interface kcsw_rsp_if
    import kcsw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] count;
    logic               dropped;

    modport source (output valid, count, dropped, input ready);
    modport sink   (input valid, count, dropped, output ready);
endinterface

// ===== rtl/kcsw_slot_mem.sv =====
// ============================================================================
// kcsw_slot_mem
// slot table: one write port, one read port, registered read data
// ============================================================================
module kcsw_slot_mem
    import kcsw_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  slot_t         wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output slot_t         rdata
);

    slot_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/kcsw_seq.sv =====
// ============================================================================
// kcsw_seq
// access sequencer: clear pass, slot scan, write-back and result
// ============================================================================
module kcsw_seq
    import kcsw_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  req_item_t     item,
    output logic          idle,
    output logic          res_valid,
    input  logic          res_ack,
    output rsp_item_t     res,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output slot_t         mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  slot_t         mem_rdata
);

    localparam int SUM_W         = AW + CNT_W;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg,     state_next;
    logic [AW-1:0]    idx_reg,       idx_next;
    logic             issue_reg,     issue_next;
    logic             vld_reg,       vld_next;
    logic             last_reg,      last_next;
    logic [AW-1:0]    paddr_reg,     paddr_next;
    req_item_t        item_reg,      item_next;
    logic             hit_reg,       hit_next;
    logic [AW-1:0]    hit_addr_reg,  hit_addr_next;
    logic [CNT_W-1:0] hit_cnt_reg,   hit_cnt_next;
    logic             free_reg,      free_next;
    logic [AW-1:0]    free_addr_reg, free_addr_next;
    logic [SUM_W-1:0] sum_reg,       sum_next;
    rsp_item_t        res_reg,       res_next;

    logic               live;
    logic               drain;
    logic [31:0]        sum_ext;
    logic [TOTAL_W-1:0] total;
    logic [CNT_W:0]     dep_sum;

    assign live    = (mem_rdata.cnt != '0);
    assign drain   = (item_reg.kind == KIND_WITHDRAW) && (item_reg.item_key == '0);
    assign sum_ext = 32'(sum_reg);
    assign total   = (sum_ext > 32'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
    assign dep_sum = {1'b0, hit_cnt_reg} + {1'b0, item_reg.amount};

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        vld_next       = 1'b0;
        last_next      = 1'b0;
        paddr_next     = paddr_reg;
        item_next      = item_reg;
        hit_next       = hit_reg;
        hit_addr_next  = hit_addr_reg;
        hit_cnt_next   = hit_cnt_reg;
        free_next      = free_reg;
        free_addr_next = free_addr_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                if (idx_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    idx_next   = '0;
                    issue_next = 1'b1;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    sum_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // read issue side
                if (issue_reg)
                begin
                    mem_re     = 1'b1;
                    idx_next   = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                    issue_next = (idx_reg != LAST);
                end
                vld_next   = issue_reg;
                last_next  = issue_reg && (idx_reg == LAST);
                paddr_next = idx_reg;
                // read data side, one slot behind
                if (vld_reg)
                begin
                    if (live)
                    begin
                        sum_next = sum_reg + SUM_W'(mem_rdata.cnt);
                        if (!hit_reg && (mem_rdata.key == item_reg.item_key))
                        begin
                            hit_next      = 1'b1;
                            hit_addr_next = paddr_reg;
                            hit_cnt_next  = mem_rdata.cnt;
                        end
                        if (drain)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = paddr_reg;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next      = 1'b1;
                        free_addr_next = paddr_reg;
                    end
                    if (last_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                res_next   = '0;
                state_next = ST_DONE;
                case (item_reg.kind)
                    KIND_DEPOSIT:
                    begin
                        if ((item_reg.item_key != '0) && (item_reg.amount != '0))
                        begin
                            if (hit_reg)
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = hit_addr_reg;
                                mem_wdata.key = item_reg.item_key;
                                mem_wdata.cnt = dep_sum[CNT_W] ? {CNT_W{1'b1}}
                                                               : dep_sum[CNT_W-1:0];
                            end
                            else if (free_reg)
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = free_addr_reg;
                                mem_wdata.key = item_reg.item_key;
                                mem_wdata.cnt = item_reg.amount;
                            end
                            else
                            begin
                                res_next.dropped = 1'b1;
                            end
                        end
                    end
                    KIND_WITHDRAW:
                    begin
                        if (item_reg.item_key == '0)
                        begin
                            res_next.count = total;
                        end
                        else if (hit_reg)
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = hit_addr_reg;
                            mem_wdata.key = item_reg.item_key;
                            if (item_reg.amount >= hit_cnt_reg)
                            begin
                                mem_wdata.cnt  = '0;
                                res_next.count = TOTAL_W'(hit_cnt_reg);
                            end
                            else
                            begin
                                mem_wdata.cnt  = hit_cnt_reg - item_reg.amount;
                                res_next.count = TOTAL_W'(item_reg.amount);
                            end
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (item_reg.item_key == '0)
                        begin
                            res_next.count = total;
                        end
                        else if (hit_reg)
                        begin
                            res_next.count = TOTAL_W'(hit_cnt_reg);
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
            issue_reg <= 1'b0;
            vld_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            issue_reg <= issue_next;
            vld_reg   <= vld_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        paddr_reg     <= paddr_next;
        item_reg      <= item_next;
        hit_reg       <= hit_next;
        hit_addr_reg  <= hit_addr_next;
        hit_cnt_reg   <= hit_cnt_next;
        free_reg      <= free_next;
        free_addr_reg <= free_addr_next;
        sum_reg       <= sum_next;
        res_reg       <= res_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

// ===== rtl/keyed_count_store_withdraw_top.sv =====
// ============================================================================
// keyed_count_store_withdraw_top
// associative counter table with deposit, withdraw and query accesses
// ============================================================================
// A table of SLOTS slots, each holding a 16-bit item key and a 16-bit count, kept
// in one synchronous memory. A slot with a zero count is empty. Every access
// scans the whole table, one memory read per cycle, then does the write-back
// and presents the result, which is held in the sequencer until the output
// register takes it; the single read port of the slot memory sets the pace
// of the scan. The request channel
// takes one item at a time; the result goes to an output register, so a new
// item is taken while the previous result still waits on the response channel.
// After reset the block runs a clearing pass that zeroes every slot, and
// takes no item until it is done. Deposits saturate a slot at 65535;
// totals for key 0 saturate at the 22-bit maximum while the slots are still
// drained in full. A deposit that finds neither its key nor an empty slot is
// discarded and flagged with dropped.
module keyed_count_store_withdraw_top
    import kcsw_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    kcsw_req_if.sink      req,
    kcsw_rsp_if.source    rsp
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // sequencer to memory
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    slot_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    slot_t         mem_rdata;

    // sequencer handshake
    logic      seq_idle;
    logic      start;
    req_item_t item;
    logic      res_valid;
    logic      res_ack;
    rsp_item_t res;

    // output register
    logic      out_valid_reg, out_valid_next;
    rsp_item_t out_item_reg;

    assign item.kind     = req.kind;
    assign item.item_key = req.item_key;
    assign item.amount   = req.amount;

    // one item in flight; ready only while the sequencer waits
    assign req.ready = seq_idle;
    assign start     = req.valid && seq_idle;

    kcsw_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    kcsw_slot_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result moves into the output register once it is empty or being drained
    assign res_ack = res_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_item_reg <= res;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.count   = out_item_reg.count;
    assign rsp.dropped = out_item_reg.dropped;

    // a drain write and the read issued with it always target different slots
    a_no_rw_collision: assert property (
        @(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr)
    ) else $error("slot memory read and write hit the same slot");

    // the sequencer never offers a result while it is open for a new item
    a_result_not_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> !seq_idle
    ) else $error("result offered while sequencer idle");

    // after an item is taken the block is busy for the scan
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready
    ) else $error("request accepted twice in a row");

    // a dropped deposit always reports a zero count
    a_dropped_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.dropped) |-> (rsp.count == '0)
    ) else $error("dropped result carries a count");

endmodule
